// File: rtl/flfm_pkg.sv
// shared types and constants for the feed line failover monitor
`default_nettype none

package flfm_pkg;

  localparam int unsigned LinesDef = 8;

  localparam int unsigned ActW    = 8;
  localparam int unsigned RoundsW = 3;
  localparam int unsigned ActiveW = 4;
  localparam int unsigned SelW    = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 4;

  localparam logic [RoundsW-1:0] CheckRoundsRst = RoundsW'(3);
  localparam logic [ActiveW-1:0] ActiveLinesRst = ActiveW'(8);
  localparam logic [RoundsW-1:0] CountMax       = '1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCheckRounds = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgActiveLines = CfgIdxW'(1);

  typedef struct packed {
    logic [RoundsW-1:0] check_rounds;
    logic [ActiveW-1:0] active_lines;
  } cfg_t;

  typedef struct packed {
    logic [SelW-1:0] selected_line;
    logic            switched;
    logic            no_data_alarm;
    logic            checking;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/flfm_pick.sv
// priority pick of the lowest other active line whose count hits the target
`default_nettype none

module flfm_pick #(
  parameter int unsigned LINES = flfm_pkg::LinesDef,
  parameter int unsigned LW    = $clog2(LINES)
) (
  input  wire logic [flfm_pkg::RoundsW-1:0] cnt_i [LINES],
  input  wire logic [LW-1:0]                cur_i,
  input  wire logic [flfm_pkg::RoundsW-1:0] target_i,
  input  wire logic [flfm_pkg::ActiveW-1:0] active_lines_i,
  output logic                              found_o,
  output logic [LW-1:0]                     idx_o
);

  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    // scan downwards so the lowest hit wins
    for (int i = LINES - 1; i >= 0; i--) begin
      if ((32'(i) < 32'(active_lines_i)) && (LW'(i) != cur_i) &&
          (cnt_i[i] == target_i)) begin
        found_o = 1'b1;
        idx_o   = LW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/flfm_core.sv
// monitor state: pending mask, round counters, selection and check window
`default_nettype none

module flfm_core #(
  parameter int unsigned LINES = flfm_pkg::LinesDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      step_i,
  input  wire logic [flfm_pkg::ActW-1:0] activity_i,
  input  wire flfm_pkg::cfg_t            cfg_i,
  output flfm_pkg::result_t              res_o
);

  localparam int unsigned LW = $clog2(LINES);

  logic [LINES-1:0]                pending_q, pending_d;
  logic [flfm_pkg::RoundsW-1:0]    cnt_q [LINES];
  logic [flfm_pkg::RoundsW-1:0]    cnt_d [LINES];
  logic [LW-1:0]                   cur_q, cur_d;
  logic                            chk_q, chk_d;
  logic [flfm_pkg::RoundsW-1:0]    rl_q, rl_d;
  logic                            have_q, have_d;

  logic [LINES-1:0]                amask;
  logic [LINES+flfm_pkg::ActW-1:0] act_wide;
  logic [LINES-1:0]                pend_a;
  logic                            do_decide;
  logic                            sw;
  logic                            found;
  logic [LW-1:0]                   pick_idx;
  logic [LW+flfm_pkg::SelW-1:0]    cur_wide;

  assign act_wide = {{LINES{1'b0}}, activity_i};

  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      amask[i] = (32'(i) < 32'(cfg_i.active_lines));
    end
  end

  assign pend_a = pending_q | (act_wide[LINES-1:0] & amask);

  flfm_pick #(
    .LINES (LINES),
    .LW    (LW)
  ) u_pick (
    .cnt_i          (cnt_d),
    .cur_i          (cur_q),
    .target_i       (cfg_i.check_rounds),
    .active_lines_i (cfg_i.active_lines),
    .found_o        (found),
    .idx_o          (pick_idx)
  );

  always_comb begin
    pending_d = pend_a;
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    chk_d     = chk_q;
    rl_d      = rl_q;
    have_d    = have_q;
    do_decide = 1'b0;
    sw        = 1'b0;

    if (!chk_q) begin
      if (pend_a[cur_q]) begin
        pending_d[cur_q] = 1'b0;
        have_d           = 1'b1;
      end else begin
        for (int i = 0; i < LINES; i++) begin
          cnt_d[i] = '0;
        end
        rl_d = cfg_i.check_rounds;
        if (cfg_i.check_rounds == '0) begin
          do_decide = 1'b1;
        end else begin
          chk_d = 1'b1;
        end
      end
    end else begin
      for (int i = 0; i < LINES; i++) begin
        if (amask[i] && pend_a[i]) begin
          if (cnt_q[i] != flfm_pkg::CountMax) begin
            cnt_d[i] = cnt_q[i] + 1'b1;
          end
          pending_d[i] = 1'b0;
        end
      end
      if (rl_q != '0) begin
        rl_d = rl_q - 1'b1;
      end
      if (rl_d == '0) begin
        chk_d     = 1'b0;
        do_decide = 1'b1;
      end
    end

    // decision (window closed, or zero check rounds): fail over only if the selected line stayed silent
    if (do_decide) begin
      have_d = 1'b0;
      if ((cnt_d[cur_q] == '0) && found) begin
        cur_d = pick_idx;
        sw    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      for (int i = 0; i < LINES; i++) begin
        cnt_q[i] <= '0;
      end
      cur_q  <= '0;
      chk_q  <= 1'b0;
      rl_q   <= '0;
      have_q <= 1'b1;
    end else if (step_i) begin
      pending_q <= pending_d;
      cnt_q     <= cnt_d;
      cur_q     <= cur_d;
      chk_q     <= chk_d;
      rl_q      <= rl_d;
      have_q    <= have_d;
    end
  end

  assign cur_wide = {{flfm_pkg::SelW{1'b0}}, cur_d};

  assign res_o.selected_line = cur_wide[flfm_pkg::SelW-1:0];
  assign res_o.switched      = sw;
  assign res_o.no_data_alarm = ~have_d;
  assign res_o.checking      = chk_d;

  a_window_has_rounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_q |-> (rl_q != '0))
    else $error("check window open with no rounds left");

  a_idle_no_rounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !chk_q |-> (rl_q == '0))
    else $error("rounds left outside a check window");

  a_switch_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && sw) |=> (cur_q != $past(cur_q)))
    else $error("switch flagged but selection unchanged");

  a_switch_clears_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && sw) |=> !have_q)
    else $error("switch without a failed read");

endmodule

`default_nettype wire

// File: rtl/feed_line_failover_monitor.sv
// top level: config registers, request input register, core and result register
//
//   channel   dir   handshake                  payload
//   in        in    in_valid_i / in_ready_o    activity_mask_i
//   out       out   out_valid_o / out_ready_i  selected_line_o, switched_o,
//                                              no_data_alarm_o, checking_o
//   cfg       in    cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// one request per cycle sustained while out_ready_i is high; each request is
// registered, processed in a single pass through the core and lands in the
// result register. reset puts the core in monitor mode on line 0 with data
// present and the config registers at their defaults. a stalled result holds
// the core; the input register still takes one more request and the pass
// through the core waits until the result slot frees.
`default_nettype none

module feed_line_failover_monitor #(
  parameter int unsigned LINES = flfm_pkg::LinesDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [flfm_pkg::ActW-1:0]    activity_mask_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [flfm_pkg::SelW-1:0]         selected_line_o,
  output logic                              switched_o,
  output logic                              no_data_alarm_o,
  output logic                              checking_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [flfm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [flfm_pkg::CfgW-1:0]    cfg_wdata_i
);

  flfm_pkg::cfg_t              cfg_q;
  logic                        in_vq;
  logic [flfm_pkg::ActW-1:0]   act_q;
  logic                        out_vq;
  flfm_pkg::result_t           res_q;
  flfm_pkg::result_t           res_d;
  logic                        proc;

  assign proc       = in_vq && (!out_vq || out_ready_i);
  assign in_ready_o = !in_vq || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.check_rounds <= flfm_pkg::CheckRoundsRst;
      cfg_q.active_lines <= flfm_pkg::ActiveLinesRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == flfm_pkg::CfgCheckRounds) begin
        cfg_q.check_rounds <= cfg_wdata_i[flfm_pkg::RoundsW-1:0];
      end else if (cfg_idx_i == flfm_pkg::CfgActiveLines) begin
        cfg_q.active_lines <= cfg_wdata_i[flfm_pkg::ActiveW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq  <= 1'b0;
      out_vq <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_vq <= 1'b1;
      end else if (proc) begin
        in_vq <= 1'b0;
      end
      if (proc) begin
        out_vq <= 1'b1;
      end else if (out_ready_i) begin
        out_vq <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q <= activity_mask_i;
    end
    if (proc) begin
      res_q <= res_d;
    end
  end

  flfm_core #(
    .LINES (LINES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (proc),
    .activity_i (act_q),
    .cfg_i      (cfg_q),
    .res_o      (res_d)
  );

  assign out_valid_o     = out_vq;
  assign selected_line_o = res_q.selected_line;
  assign switched_o      = res_q.switched;
  assign no_data_alarm_o = res_q.no_data_alarm;
  assign checking_o      = res_q.checking;

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vq && !out_ready_i) |-> !proc)
    else $error("result register overwritten while stalled");

  a_pending_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vq && !proc) |=> in_vq)
    else $error("buffered request dropped");

  a_accept_into_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> in_vq)
    else $error("accepted request not buffered");

endmodule

`default_nettype wire
